FILE: sv/bar_pkg.sv
// Shared types, constants and the altitude table for the barometric residual unit.
package bar_pkg;

    localparam int TABLE_SEGMENTS = 256;
    localparam int IDX_W          = $clog2(TABLE_SEGMENTS);
    localparam int ROM_AW         = $clog2(TABLE_SEGMENTS + 1);
    localparam int PROD_W         = 24 + IDX_W;
    localparam int ALT_W          = 32;
    localparam int ENT_DEPTH      = 3;
    localparam int ENT_AW         = $clog2(ENT_DEPTH);

    localparam logic [23:0]       MIN_PRESSURE  = 24'd16;
    localparam logic [15:0]       SIGMA_RESET   = 16'd1024;
    localparam logic [63:0]       REF_PRESSURE  = 64'd1620640;
    localparam logic [63:0]       Q30_ONE       = 64'd1 << 30;
    localparam logic [63:0]       ALT_DEN       = 64'd649 << 20;
    localparam logic signed [33:0] S34_MAX      = 34'sd2147483647;
    localparam logic signed [33:0] S34_MIN      = -34'sd2147483648;

    typedef enum logic [1:0] {
        KIND_SAMPLE,
        KIND_EVAL,
        KIND_ACCEPT,
        KIND_CLEAR
    } t_kind;

    typedef enum logic [1:0] {
        STAT_NOT_READY,
        STAT_SKIP,
        STAT_APPLY
    } t_status;

    typedef enum logic [1:0] {
        CFG_NEGATE,
        CFG_SIGMA,
        CFG_REANCHOR
    } t_cfg_idx;

    // Entries of the anchor memory
    typedef enum logic [ENT_AW-1:0] {
        ENT_BARO,
        ENT_POS,
        ENT_LAST
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC_RD,
        S_ACC_WR,
        S_ACC_POS,
        S_RD_BARO,
        S_RD_POS,
        S_LOOKUP,
        S_SET_BARO,
        S_SET_POS,
        S_WR_LAST,
        S_RESID,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic                    done;
        logic signed [ALT_W-1:0] alt;
    } t_lk_rsp;

    typedef logic signed [ALT_W-1:0] t_alt_rom [0:TABLE_SEGMENTS];

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > S34_MAX) return 32'sh7FFF_FFFF;
        if (v < S34_MIN) return 32'sh8000_0000;
        return 32'(v);
    endfunction

    // Elaboration-time helpers that build the node table
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bv;
        rem = v;
        res = 64'd0;
        bv  = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (bv > rem) bv = bv >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (bv != 64'd0) begin
                if (rem >= res + bv) begin
                    rem = rem - (res + bv);
                    res = (res >> 1) + bv;
                end else begin
                    res = res >> 1;
                end
                bv = bv >> 2;
            end
        end
        return res;
    endfunction

    function automatic longint log2_q32(input logic [63:0] x);
        int          n;
        logic [63:0] y;
        logic [63:0] frac;
        n = 0;
        for (int i = 0; i < 63; i++) begin
            if ((x >> (n + 1)) != 64'd0) n = n + 1;
        end
        y    = x << (30 - n);
        frac = 64'd0;
        for (int i = 1; i <= 32; i++) begin
            y = (y * y) >> 30;
            if (y >= (Q30_ONE << 1)) begin
                y    = y >> 1;
                frac = frac | (64'd1 << (32 - i));
            end
        end
        return longint'(n) * (longint'(1) <<< 32) + longint'(frac);
    endfunction

    function automatic logic [63:0] exp2_frac_q30(input logic [63:0] f,
                                                  input logic [30:0][63:0] roots);
        logic [63:0] r;
        r = Q30_ONE;
        for (int i = 1; i <= 30; i++) begin
            if (((f >> (32 - i)) & 64'd1) != 64'd0) r = (r * roots[i]) >> 30;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] altitude_of(input logic [63:0] p,
                                                       input logic [30:0][63:0] roots);
        longint      e;
        longint      ip;
        longint      num;
        longint      q;
        logic [63:0] f;
        logic [63:0] ratio;
        logic [63:0] mag;
        logic        neg;
        ratio = 64'd0;
        if (p != 64'd0) begin
            e     = (log2_q32(p) - log2_q32(REF_PRESSURE)) * 1000 / 5256;
            f     = 64'(e) & 64'h0000_0000_FFFF_FFFF;
            ip    = e >>> 32;
            ratio = exp2_frac_q30(f, roots);
            if (ip < 0) begin
                ratio = (ip <= -63) ? 64'd0 : (ratio >> (-ip));
            end else if (ip > 0) begin
                ratio = ratio << ((ip > 2) ? 2 : ip);
            end
        end
        num = longint'(28814) * longint'(Q30_ONE) - longint'(28808) * longint'(ratio);
        q   = num * 1000;
        neg = (q < 0);
        mag = neg ? 64'(-q) : 64'(q);
        mag = (mag + ALT_DEN / 2) / ALT_DEN;
        return neg ? -32'(mag) : 32'(mag);
    endfunction

    function automatic t_alt_rom build_rom();
        logic [30:0][63:0] roots;
        t_alt_rom          rom;
        roots[0] = Q30_ONE << 1;
        for (int k = 1; k <= 30; k++) roots[k] = isqrt64(roots[k-1] << 30);
        for (int k = 0; k <= TABLE_SEGMENTS; k++) begin
            rom[k] = altitude_of((64'(k) << 24) / 64'(TABLE_SEGMENTS), roots);
        end
        return rom;
    endfunction

    localparam t_alt_rom ALT_ROM = build_rom();

endpackage

FILE: sv/baro_altitude_residual_unit.sv
// Top level of the barometric altitude residual unit: sequencer, anchor memory, result stage.
//
//   Channel | Direction | Handshake                  | Payload
//   --------+-----------+----------------------------+-------------------------------------
//   in      | to block  | i_in_valid / o_in_ready    | kind, pressure, reading_valid,
//           |           |                            | vertical_position
//   out     | from block| o_out_valid / i_out_ready  | status, residual, variance,
//           |           |                            | measured_change, predicted_change,
//           |           |                            | anchor_set
//   cfg     | to block  | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
// Steps: sample and anchor-clear items finish in the idle step; an accept item does too, or
// when re-anchoring reads the last altitude and writes both anchors. An evaluate item with no
// usable sample goes straight to the emit step; one that goes through the altitude lookup reads
// both anchors, waits on the five-stage table interpolation and then writes the anchor memory.
// Reset is synchronous and active low; it clears the sequencer, the pending sample and the
// anchor memory's entry valid bits, so no clearing pass is needed.
// A stalled output holds only the result stage: the block keeps taking items while a result
// waits, and an evaluate item that finishes meanwhile holds in its emit step.
module baro_altitude_residual_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_kind,
    input  logic [23:0]        i_pressure,
    input  logic               i_reading_valid,
    input  logic signed [31:0] i_vertical_position,

    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_residual,
    output logic [31:0]        o_variance,
    output logic signed [31:0] o_measured_change,
    output logic signed [31:0] o_predicted_change,
    output logic               o_anchor_set,

    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);

    // Sequencer
    bar_pkg::t_state  r_state;
    bar_pkg::t_state  n_state;

    // Configuration
    logic             r_negate;
    logic [15:0]      r_sigma;
    logic             r_reanchor;

    // Pending sample and anchor state
    logic             r_pend_flag;
    logic             r_pend_ok;
    logic [23:0]      r_pend_pres;
    logic             r_anchor_flag;
    logic [bar_pkg::ENT_DEPTH-1:0] r_ent_ok;
    logic             r_rd_ok;

    // Working registers of one evaluate item
    logic signed [31:0] r_vpos;
    logic signed [31:0] r_baro;
    logic signed [31:0] r_pos;
    logic signed [31:0] r_alt;
    logic               r_do_apply;
    bar_pkg::t_status   r_stat;
    logic               r_aset;
    logic signed [31:0] r_meas;
    logic signed [31:0] r_pred;
    logic signed [31:0] r_resid;
    logic [31:0]        r_var;

    // Result stage
    logic               r_out_valid;
    bar_pkg::t_status   r_out_stat;
    logic signed [31:0] r_out_resid;
    logic [31:0]        r_out_var;
    logic signed [31:0] r_out_meas;
    logic signed [31:0] r_out_pred;
    logic               r_out_aset;

    // Combinational
    bar_pkg::t_kind     w_kind;
    logic               w_acc;
    logic               w_pend_good;
    logic               w_start;
    logic               w_emit;
    logic               w_we;
    bar_pkg::t_entry    w_waddr;
    bar_pkg::t_entry    w_raddr;
    logic [31:0]        w_wdata;
    logic [31:0]        w_rdata;
    logic signed [31:0] w_rd_val;
    logic signed [32:0] w_dalt;
    logic signed [33:0] w_meas_raw;
    logic signed [33:0] w_pdiff;
    bar_pkg::t_lk_rsp   w_lk;

    assign w_kind      = bar_pkg::t_kind'(i_kind);
    // take no item while reset is held
    assign o_in_ready  = i_rst_n && (r_state == bar_pkg::S_IDLE);
    assign w_acc       = i_in_valid && o_in_ready;
    assign w_pend_good = r_pend_ok && (r_pend_pres > bar_pkg::MIN_PRESSURE);
    // kick the lookup only for a usable pending sample
    assign w_start     = w_acc && (w_kind == bar_pkg::KIND_EVAL) && r_pend_flag && w_pend_good;
    assign w_emit      = (r_state == bar_pkg::S_EMIT) && (!r_out_valid || i_out_ready);

    // an entry never written since reset, or an anchor entry since anchor clear, reads as zero
    assign w_rd_val    = r_rd_ok ? $signed(w_rdata) : 32'sd0;

    assign w_dalt      = 33'(r_alt) - 33'(r_baro);
    assign w_meas_raw  = r_negate ? -34'(w_dalt) : 34'(w_dalt);
    assign w_pdiff     = 34'(r_vpos) - 34'(r_pos);

    bar_interp u_interp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_pressure (r_pend_pres),
        .o_rsp      (w_lk)
    );

    bar_ram #(
        .WIDTH (bar_pkg::ALT_W),
        .DEPTH (bar_pkg::ENT_DEPTH)
    ) u_anchor_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bar_pkg::S_IDLE: begin
                if (w_acc) begin
                    case (w_kind)
                        bar_pkg::KIND_EVAL: begin
                            n_state = w_start ? bar_pkg::S_RD_BARO : bar_pkg::S_EMIT;
                        end
                        bar_pkg::KIND_ACCEPT: begin
                            if (r_reanchor) n_state = bar_pkg::S_ACC_RD;
                        end
                        default: ;
                    endcase
                end
            end
            bar_pkg::S_ACC_RD:   n_state = bar_pkg::S_ACC_WR;
            bar_pkg::S_ACC_WR:   n_state = bar_pkg::S_ACC_POS;
            bar_pkg::S_ACC_POS:  n_state = bar_pkg::S_IDLE;
            bar_pkg::S_RD_BARO:  n_state = bar_pkg::S_RD_POS;
            bar_pkg::S_RD_POS:   n_state = bar_pkg::S_LOOKUP;
            bar_pkg::S_LOOKUP: begin
                if (w_lk.done) begin
                    n_state = r_do_apply ? bar_pkg::S_WR_LAST : bar_pkg::S_SET_BARO;
                end
            end
            bar_pkg::S_SET_BARO: n_state = bar_pkg::S_SET_POS;
            bar_pkg::S_SET_POS:  n_state = bar_pkg::S_EMIT;
            bar_pkg::S_WR_LAST:  n_state = bar_pkg::S_RESID;
            bar_pkg::S_RESID:    n_state = bar_pkg::S_EMIT;
            bar_pkg::S_EMIT: begin
                if (w_emit) n_state = bar_pkg::S_IDLE;
            end
            default:             n_state = bar_pkg::S_IDLE;
        endcase
    end

    // Anchor memory access per state
    always_comb begin
        w_we    = 1'b0;
        w_waddr = bar_pkg::ENT_BARO;
        w_wdata = r_alt;
        w_raddr = bar_pkg::ENT_POS;
        unique case (r_state)
            bar_pkg::S_ACC_RD: begin
                w_raddr = bar_pkg::ENT_LAST;
            end
            bar_pkg::S_ACC_WR: begin
                w_we    = 1'b1;
                w_waddr = bar_pkg::ENT_BARO;
                w_wdata = w_rd_val;
            end
            bar_pkg::S_ACC_POS: begin
                w_we    = 1'b1;
                w_waddr = bar_pkg::ENT_POS;
                w_wdata = r_vpos;
            end
            bar_pkg::S_RD_BARO: begin
                w_raddr = bar_pkg::ENT_BARO;
            end
            bar_pkg::S_SET_BARO: begin
                w_we    = 1'b1;
                w_waddr = bar_pkg::ENT_BARO;
                w_wdata = r_alt;
            end
            bar_pkg::S_SET_POS: begin
                w_we    = 1'b1;
                w_waddr = bar_pkg::ENT_POS;
                w_wdata = r_vpos;
            end
            bar_pkg::S_WR_LAST: begin
                w_we    = 1'b1;
                w_waddr = bar_pkg::ENT_LAST;
                w_wdata = r_alt;
            end
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= bar_pkg::S_IDLE;
            r_negate      <= 1'b0;
            r_sigma       <= bar_pkg::SIGMA_RESET;
            r_reanchor    <= 1'b0;
            r_pend_flag   <= 1'b0;
            r_pend_ok     <= 1'b0;
            r_anchor_flag <= 1'b0;
            r_ent_ok      <= '0;
            r_rd_ok       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (bar_pkg::t_cfg_idx'(i_cfg_idx))
                    bar_pkg::CFG_NEGATE:   r_negate   <= i_cfg_data[0];
                    bar_pkg::CFG_SIGMA:    r_sigma    <= i_cfg_data;
                    bar_pkg::CFG_REANCHOR: r_reanchor <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (w_acc) begin
                case (w_kind)
                    bar_pkg::KIND_SAMPLE: begin
                        r_pend_flag <= 1'b1;
                        r_pend_ok   <= i_reading_valid;
                    end
                    bar_pkg::KIND_EVAL: begin
                        r_pend_flag <= 1'b0;
                    end
                    bar_pkg::KIND_CLEAR: begin
                        // drop the anchor; both anchor entries read as zero again
                        r_anchor_flag              <= 1'b0;
                        r_ent_ok[bar_pkg::ENT_BARO] <= 1'b0;
                        r_ent_ok[bar_pkg::ENT_POS]  <= 1'b0;
                    end
                    default: ;
                endcase
            end

            if (w_we) r_ent_ok[w_waddr] <= 1'b1;
            if (r_state == bar_pkg::S_SET_POS) r_anchor_flag <= 1'b1;

            r_rd_ok <= r_ent_ok[w_raddr];

            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (w_acc && (w_kind == bar_pkg::KIND_SAMPLE)) r_pend_pres <= i_pressure;
        if (w_acc) r_vpos <= i_vertical_position;

        if (w_acc && (w_kind == bar_pkg::KIND_EVAL)) begin
            if (!r_pend_flag) begin
                r_stat <= bar_pkg::STAT_NOT_READY;
            end else if (!w_pend_good) begin
                r_stat <= bar_pkg::STAT_SKIP;
            end else if (r_anchor_flag) begin
                r_stat <= bar_pkg::STAT_APPLY;
            end else begin
                r_stat <= bar_pkg::STAT_NOT_READY;
            end
            r_aset     <= r_pend_flag && w_pend_good && !r_anchor_flag;
            r_do_apply <= r_anchor_flag;
            r_meas     <= '0;
            r_pred     <= '0;
            r_resid    <= '0;
            r_var      <= '0;
        end

        // baro anchor data arrives in the step after its read, S_RD_POS
        if (r_state == bar_pkg::S_RD_POS) r_baro <= w_rd_val;
        if (r_state == bar_pkg::S_LOOKUP) r_pos  <= w_rd_val;
        if (w_lk.done) r_alt <= $signed(w_lk.alt);

        if (r_state == bar_pkg::S_WR_LAST) begin
            r_meas <= bar_pkg::sat32(w_meas_raw);
            r_pred <= bar_pkg::sat32(w_pdiff);
            r_var  <= 32'(r_sigma) * 32'(r_sigma);
        end
        if (r_state == bar_pkg::S_RESID) begin
            r_resid <= bar_pkg::sat32(34'(r_meas) - 34'(r_pred));
        end

        if (w_emit) begin
            r_out_stat  <= r_stat;
            r_out_resid <= r_resid;
            r_out_var   <= r_var;
            r_out_meas  <= r_meas;
            r_out_pred  <= r_pred;
            r_out_aset  <= r_aset;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out_stat;
    assign o_residual         = r_out_resid;
    assign o_variance         = r_out_var;
    assign o_measured_change  = r_out_meas;
    assign o_predicted_change = r_out_pred;
    assign o_anchor_set       = r_out_aset;

`ifndef SYNTHESIS
    a_done_in_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lk.done |-> (r_state == bar_pkg::S_LOOKUP))
        else $error("lookup finished outside the lookup step");

    a_aset_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_anchor_set) |-> (o_status == bar_pkg::STAT_NOT_READY))
        else $error("anchor set reported with a status other than not ready");

    a_zero_unless_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != bar_pkg::STAT_APPLY)) |->
        ((o_residual == 32'sd0) && (o_variance == 32'd0) &&
         (o_measured_change == 32'sd0) && (o_predicted_change == 32'sd0)))
        else $error("nonzero result fields without an applied update");

    a_write_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> !o_in_ready)
        else $error("anchor memory written while items are being taken");
`endif

endmodule

FILE: sv/bar_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module bar_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/bar_interp.sv
// Pressure-to-altitude lookup: node table read and linear interpolation.
module bar_interp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [23:0]      i_pressure,
    output bar_pkg::t_lk_rsp o_rsp
);

    logic [4:0]                       r_stg;
    logic [bar_pkg::IDX_W-1:0]        r_idx;
    logic [23:0]                      r_frac;
    logic signed [31:0]               r_q;
    logic signed [31:0]               r_lo;
    logic signed [57:0]               r_prod;
    logic signed [31:0]               r_alt;

    logic [bar_pkg::PROD_W-1:0]       w_prod;
    logic [bar_pkg::ROM_AW-1:0]       w_addr;
    logic signed [32:0]               w_diff;
    logic signed [57:0]               w_mul;
    logic signed [57:0]               w_bias;
    logic signed [57:0]               w_sum;
    logic signed [31:0]               w_step;

    assign w_prod = bar_pkg::PROD_W'(i_pressure) * bar_pkg::PROD_W'(bar_pkg::TABLE_SEGMENTS);

    // first stage reads the lower node, second the upper one
    assign w_addr = r_stg[0] ? bar_pkg::ROM_AW'(r_idx)
                             : bar_pkg::ROM_AW'(r_idx) + bar_pkg::ROM_AW'(1);

    assign w_diff = 33'(r_q) - 33'(r_lo);
    assign w_mul  = 58'(w_diff) * 58'($signed({1'b0, r_frac}));

    // truncate toward zero on the divide by 2^24
    assign w_bias = r_prod[57] ? 58'sd16777215 : 58'sd0;
    assign w_sum  = r_prod + w_bias;
    assign w_step = 32'(w_sum >>> 24);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg <= '0;
        end else begin
            r_stg <= {r_stg[3:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_idx  <= w_prod[bar_pkg::PROD_W-1:24];
            r_frac <= w_prod[23:0];
        end
        r_q <= bar_pkg::ALT_ROM[w_addr];
        if (r_stg[1]) r_lo   <= r_q;
        if (r_stg[2]) r_prod <= w_mul;
        if (r_stg[3]) r_alt  <= r_lo + w_step;
    end

    assign o_rsp.done = r_stg[4];
    assign o_rsp.alt  = r_alt;

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the barometric altitude residual unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bar_pkg::*;

    // Run control
    localparam int LIMIT_CYCLES  = 200000;
    localparam int SETTLE_CYCLES = 16;     // longest item is an evaluate with lookup
    localparam int DRAIN_CYCLES  = 40;
    localparam int MAX_IDLE      = 17;
    localparam int HOLD_CYCLES   = 400;

    // Register index past the end of the list; the block must ignore it
    localparam logic [1:0] CFG_SPARE = 2'd3;

    // Fixed-point constants of the altitude model
    localparam logic [23:0]     FLOOR_PRESSURE = 24'd16;       // 1 Pa in 1/16 Pa
    localparam logic [23:0]     SEA_LEVEL_P    = 24'd1620640;  // 101290 Pa in 1/16 Pa
    localparam longint unsigned Q30_UNIT       = 64'd1 << 30;
    localparam longint unsigned ALT_DIVISOR    = 64'd649 << 20;
    localparam longint          S32_HI         = 64'sd2147483647;
    localparam longint          S32_LO         = -64'sd2147483648;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_kind;
    logic [23:0]        i_pressure;
    logic               i_reading_valid;
    logic signed [31:0] i_vertical_position;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [1:0]         o_status;
    logic signed [31:0] o_residual;
    logic [31:0]        o_variance;
    logic signed [31:0] o_measured_change;
    logic signed [31:0] o_predicted_change;
    logic               o_anchor_set;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [15:0]        i_cfg_data;

    baro_altitude_residual_unit dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_kind              (i_kind),
        .i_pressure          (i_pressure),
        .i_reading_valid     (i_reading_valid),
        .i_vertical_position (i_vertical_position),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_status            (o_status),
        .o_residual          (o_residual),
        .o_variance          (o_variance),
        .o_measured_change   (o_measured_change),
        .o_predicted_change  (o_predicted_change),
        .o_anchor_set        (o_anchor_set),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // One expected evaluate outcome
    typedef struct {
        t_status            status;
        logic signed [31:0] residual;
        logic [31:0]        variance;
        logic signed [31:0] meas;
        logic signed [31:0] pred;
        logic               anchor_set;
    } residual_rec_t;

    residual_rec_t residual_q[$];
    int            err_count   = 0;
    int            items_sent  = 0;

    // Traffic shaping, shared by the sender, the result sink and the tests
    bit            tx_no_idle  = 1'b0;
    bit            rx_no_idle  = 1'b0;
    int            rx_hold_req = 0;

    // Altitude node table, rebuilt here from the integer procedure
    longint unsigned    root_tab [0:30];
    logic signed [31:0] node_alt [0:TABLE_SEGMENTS];

    // Shadow of the block's registers and state, at their reset values
    logic               cfg_negate    = 1'b0;
    logic [15:0]        cfg_sigma     = 16'd1024;
    logic               cfg_reanchor  = 1'b0;
    logic               held_valid    = 1'b0;
    logic [23:0]        held_pressure = 24'd0;
    logic               held_ok       = 1'b0;
    logic               anchored      = 1'b0;
    logic signed [31:0] alt_anchor    = 32'sd0;
    logic signed [31:0] pos_anchor    = 32'sd0;
    logic signed [31:0] last_alt      = 32'sd0;

    // ------------------------------------------------------------------
    // Altitude conversion
    // ------------------------------------------------------------------
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned rem;
        longint unsigned res;
        longint unsigned bitv;
        rem  = v;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 64'd0) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Base-2 log with 32 fraction bits by repeated squaring of the mantissa
    function automatic longint log2_fix(input longint unsigned x);
        int              n;
        longint unsigned y;
        longint unsigned frac;
        n = 0;
        while (n < 63 && (x >> (n + 1)) != 64'd0) n++;
        y    = x << (30 - n);
        frac = 64'd0;
        for (int i = 1; i <= 32; i++) begin
            y = (y * y) >> 30;
            if (y >= (Q30_UNIT << 1)) begin
                y    = y >> 1;
                frac = frac | (64'd1 << (32 - i));
            end
        end
        return longint'(n) * (longint'(1) << 32) + longint'(frac);
    endfunction

    // 2^f in Q30 for a 32-bit fraction f, from the root table
    function automatic longint unsigned pow2_frac(input longint unsigned f);
        longint unsigned r;
        r = Q30_UNIT;
        for (int i = 1; i <= 30; i++) begin
            if (((f >> (32 - i)) & 64'd1) != 64'd0) r = (r * root_tab[i]) >> 30;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] node_altitude(input longint unsigned p);
        longint             e;
        longint             ip;
        longint             num;
        longint             q;
        longint unsigned    f;
        longint unsigned    ratio;
        longint unsigned    mag;
        logic               neg;
        logic signed [31:0] r32;
        ratio = 64'd0;
        if (p != 64'd0) begin
            e     = (log2_fix(p) - log2_fix(64'(SEA_LEVEL_P))) * 1000 / 5256;
            f     = e & 64'h0000_0000_FFFF_FFFF;
            ip    = (e - longint'(f)) / (longint'(1) << 32);
            ratio = pow2_frac(f);
            if (ip < 0) begin
                ratio = (ip <= -63) ? 64'd0 : (ratio >> (-ip));
            end else if (ip > 0) begin
                ratio = ratio << ((ip > 2) ? 2 : ip);
            end
        end
        num = longint'(28814) * longint'(Q30_UNIT) - longint'(28808) * longint'(ratio);
        q   = num * 1000;
        neg = (q < 0);
        mag = neg ? unsigned'(-q) : unsigned'(q);
        // round to nearest, ties away from zero
        mag = (mag + ALT_DIVISOR / 2) / ALT_DIVISOR;
        r32 = 32'(mag);
        return neg ? -r32 : r32;
    endfunction

    task automatic build_node_table();
        root_tab[0] = Q30_UNIT << 1;
        for (int k = 1; k <= 30; k++) root_tab[k] = int_sqrt(root_tab[k-1] << 30);
        for (int k = 0; k <= TABLE_SEGMENTS; k++) begin
            node_alt[k] = node_altitude((64'(k) << 24) / 64'(TABLE_SEGMENTS));
        end
    endtask

    // Linear interpolation between nodes, quotient truncated toward zero
    function automatic logic signed [31:0] interp_altitude(input logic [23:0] p);
        longint unsigned prod;
        int              i;
        longint          frac;
        longint          d;
        prod = {40'd0, p} * 64'(TABLE_SEGMENTS);
        i    = int'(prod >> 24);
        frac = longint'(prod & 64'hFF_FFFF);
        if (i >= TABLE_SEGMENTS) i = TABLE_SEGMENTS - 1;
        d = longint'(node_alt[i+1]) - longint'(node_alt[i]);
        return 32'(longint'(node_alt[i]) + d * frac / (longint'(1) << 24));
    endfunction

    function automatic logic signed [31:0] clamp_s32(input longint v);
        if (v > S32_HI) return 32'sh7FFF_FFFF;
        if (v < S32_LO) return 32'sh8000_0000;
        return 32'(v);
    endfunction

    // ------------------------------------------------------------------
    // Prediction: advance the shadow state by one accepted item and queue
    // the outcome of every evaluate
    // ------------------------------------------------------------------
    task automatic baro_predict(input t_kind kind, input logic [23:0] pres, input logic ok,
                                input logic signed [31:0] vpos);
        residual_rec_t      rec;
        logic signed [31:0] alt;
        longint             meas;
        rec = '{STAT_NOT_READY, 32'sd0, 32'd0, 32'sd0, 32'sd0, 1'b0};
        case (kind)
            KIND_SAMPLE: begin
                // latest sample overwrites any unread one
                held_valid    = 1'b1;
                held_pressure = pres;
                held_ok       = ok;
            end
            KIND_ACCEPT: begin
                // differential mode moves both anchors, anchored or not
                if (cfg_reanchor) begin
                    alt_anchor = last_alt;
                    pos_anchor = vpos;
                end
            end
            KIND_CLEAR: begin
                anchored   = 1'b0;
                alt_anchor = 32'sd0;
                pos_anchor = 32'sd0;
            end
            KIND_EVAL: begin
                if (held_valid) begin
                    held_valid = 1'b0;
                    if (!held_ok || held_pressure <= FLOOR_PRESSURE) begin
                        rec.status = STAT_SKIP;
                    end else if (!anchored) begin
                        // first usable reading only sets the anchors
                        anchored       = 1'b1;
                        alt_anchor     = interp_altitude(held_pressure);
                        pos_anchor     = vpos;
                        rec.anchor_set = 1'b1;
                    end else begin
                        alt      = interp_altitude(held_pressure);
                        last_alt = alt;
                        meas     = longint'(alt) - longint'(alt_anchor);
                        if (cfg_negate) meas = -meas;
                        rec.meas     = clamp_s32(meas);
                        rec.pred     = clamp_s32(longint'(vpos) - longint'(pos_anchor));
                        rec.residual = clamp_s32(longint'(rec.meas) - longint'(rec.pred));
                        rec.variance = {16'd0, cfg_sigma} * {16'd0, cfg_sigma};
                        rec.status   = STAT_APPLY;
                    end
                end
                residual_q.push_back(rec);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Idle a random number of cycles, then hold the item until accepted.
    // Valid stays high across back-to-back items.
    task automatic send_item(input t_kind kind, input logic [23:0] pres, input logic ok,
                             input logic signed [31:0] vpos);
        int gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_kind              <= kind;
        i_pressure          <= pres;
        i_reading_valid     <= ok;
        i_vertical_position <= vpos;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        baro_predict(kind, pres, ok, vpos);
        items_sent++;
    endtask

    // Unused payload fields carry random bits
    task automatic send_sample(input logic [23:0] pres, input logic ok);
        send_item(KIND_SAMPLE, pres, ok, 32'($urandom));
    endtask

    task automatic send_eval(input logic signed [31:0] vpos);
        send_item(KIND_EVAL, 24'($urandom), 1'($urandom), vpos);
    endtask

    // Write one register once the block has drained: all results in, and
    // enough cycles for an accept or a lookup still in flight to finish
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_in_valid <= 1'b0;
        while (residual_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_NEGATE:   cfg_negate   = data[0];
            CFG_SIGMA:    cfg_sigma    = data;
            CFG_REANCHOR: cfg_reanchor = data[0];
            default:      ;
        endcase
    endtask

    // Mostly near sea level; some full-range, some at or below the floor, some just past it
    function automatic logic [23:0] pick_pressure();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return 24'(int'(SEA_LEVEL_P) - 800000 + int'($urandom_range(0, 1600000)));
        if (sel < 8) return 24'($urandom);
        if (sel == 8) return 24'($urandom_range(0, 16));
        return 24'($urandom_range(17, 80));
    endfunction

    // Mostly within about a kilometre; sometimes anywhere, to hit saturation
    function automatic logic signed [31:0] pick_position();
        if ($urandom_range(0, 7) == 0) return 32'($urandom);
        return 32'(int'($urandom_range(0, 2097152)) - 1048576);
    endfunction

    // ------------------------------------------------------------------
    // Output side: check every accepted result against the oldest
    // prediction
    // ------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $display("t=%0t %s: expected 0x%08h, actual 0x%08h", $time, name, want, got);
            err_count++;
        end
    endtask

    task automatic check_result();
        residual_rec_t want;
        if (residual_q.size() == 0) begin
            $display("t=%0t result with none pending: expected nothing, actual status %0d",
                     $time, o_status);
            err_count++;
            return;
        end
        want = residual_q.pop_front();
        compare_field("status",           32'(want.status),     32'(o_status));
        compare_field("residual",         want.residual,        o_residual);
        compare_field("variance",         want.variance,        o_variance);
        compare_field("measured_change",  want.meas,            o_measured_change);
        compare_field("predicted_change", want.pred,            o_predicted_change);
        compare_field("anchor_set",       32'(want.anchor_set), 32'(o_anchor_set));
    endtask

    // Result sink: draw a stall per result, or take a long hold on request
    initial begin : result_sink
        int   stall_left;
        logic took;
        stall_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            took = i_rst_n && i_out_ready && o_out_valid;
            if (took) check_result();
            if (rx_hold_req > 0) begin
                stall_left  = rx_hold_req;
                rx_hold_req = 0;
            end else if (took) begin
                stall_left = rx_no_idle ? 0 : $urandom_range(0, MAX_IDLE);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            i_out_ready <= i_rst_n && (stall_left == 0);
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Evaluate with nothing pending; accept in absolute mode changes nothing
    task automatic test_no_pending_sample();
        send_eval(32'sd0);
        send_item(KIND_ACCEPT, 24'($urandom), 1'b1, 32'sd77);
    endtask

    // Invalid flag, zero pressure and pressure at the 1 Pa floor all skip
    task automatic test_invalid_readings();
        send_sample(24'hFF_FFFF, 1'b0);
        send_eval(32'sd0);
        send_sample(24'd0, 1'b1);
        send_eval(32'sd0);
        send_sample(FLOOR_PRESSURE, 1'b1);
        send_eval(32'sd0);
    endtask

    // First reading just above the floor anchors; the next one saturates the
    // predicted change high and the residual low
    task automatic test_anchor_and_saturation();
        send_sample(FLOOR_PRESSURE + 24'd1, 1'b1);
        send_eval(32'sh8000_0000);
        send_sample(SEA_LEVEL_P, 1'b1);
        send_eval(32'sh7FFF_FFFF);
        send_eval(32'sd0);                     // sample already consumed
        send_sample(24'hFF_FFFF, 1'b1);
        send_sample(24'd1500000, 1'b1);        // overwrite the unread sample
        send_eval(32'sh8000_0000);
    endtask

    // Differential mode, anchor clear, negation, sigma extreme, spare index
    task automatic test_reanchor_and_registers();
        write_reg(CFG_REANCHOR, 16'hFFFF);
        send_item(KIND_ACCEPT, 24'($urandom), 1'b0, 32'sd123456);
        send_sample(24'd1600000, 1'b1);
        send_eval(32'sd130000);
        send_item(KIND_CLEAR, 24'($urandom), 1'b1, 32'($urandom));
        send_item(KIND_ACCEPT, 24'($urandom), 1'b1, -32'sd5000);
        send_sample(24'd1700000, 1'b1);
        send_eval(-32'sd5000);
        write_reg(CFG_NEGATE, 16'h0001);
        write_reg(CFG_SIGMA, 16'hFFFF);
        write_reg(CFG_SPARE, 16'hFFFF);
        send_sample(24'd1650000, 1'b1);
        send_eval(32'sd2000);
    endtask

    // Hold the sink off while the source streams updates, so the result
    // stage fills and the input stalls
    task automatic test_output_stall();
        tx_no_idle  = 1'b1;
        rx_hold_req = HOLD_CYCLES;
        for (int n = 0; n < 20; n++) begin
            send_sample(pick_pressure(), 1'b1);
            send_eval(pick_position());
        end
        tx_no_idle = 1'b0;
    endtask

    // Random traffic over several register settings
    task automatic test_random_traffic();
        int          stop_at;
        int unsigned r;
        logic [15:0] sig;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                1:       sig = 16'd0;
                2:       sig = 16'hFFFF;
                3:       sig = SIGMA_RESET;
                default: sig = 16'($urandom);
            endcase
            write_reg(CFG_NEGATE,   {15'($urandom), 1'(ph % 2)});
            write_reg(CFG_SIGMA,    sig);
            write_reg(CFG_REANCHOR, {15'($urandom), 1'(ph == 1 || ph >= 3)});
            write_reg(CFG_SPARE,    16'($urandom));
            // one stretch with no idling on either side, one on the source only
            tx_no_idle = (ph == 2 || ph == 3);
            rx_no_idle = (ph == 2);
            stop_at = items_sent + 80;
            while (items_sent < stop_at) begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    // well-formed update: sample, evaluate, sometimes accept
                    send_sample(pick_pressure(), $urandom_range(0, 15) != 0);
                    send_eval(pick_position());
                    if ($urandom_range(0, 2) == 0) begin
                        send_item(KIND_ACCEPT, 24'($urandom), 1'($urandom), pick_position());
                    end
                end else if (r < 75) begin
                    send_eval(pick_position());
                end else if (r < 85) begin
                    send_sample(pick_pressure(), 1'($urandom));
                end else if (r < 93) begin
                    send_item(KIND_ACCEPT, 24'($urandom), 1'($urandom), pick_position());
                end else begin
                    send_item(KIND_CLEAR, 24'($urandom), 1'($urandom), 32'($urandom));
                end
            end
        end
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n             <= 1'b0;
        i_in_valid          <= 1'b0;
        i_kind              <= KIND_SAMPLE;
        i_pressure          <= 24'd0;
        i_reading_valid     <= 1'b0;
        i_vertical_position <= 32'sd0;
        i_cfg_we            <= 1'b0;
        i_cfg_idx           <= CFG_NEGATE;
        i_cfg_data          <= 16'd0;
        build_node_table();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_no_pending_sample();
        test_invalid_readings();
        test_anchor_and_saturation();
        test_reanchor_and_registers();
        test_output_stall();
        test_random_traffic();

        // drop valid, drain, then leave room for any stray result
        i_in_valid <= 1'b0;
        while (residual_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Cycle budget for the whole run
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
sv/bar_pkg.sv
sv/bar_ram.sv
sv/bar_interp.sv
sv/baro_altitude_residual_unit.sv
tb/sv/tb_top.sv
